// ----- rtl/bdd_pkg.sv -----
// shared types, constants and functions of the box downscaler with ordered dither
package bdd_pkg;

   localparam int COL_W = 10;
   localparam int ROW_W = 12;

   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
   localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

   localparam logic [11:0] RST_SRC_WIDTH  = 12'd350;
   localparam logic [11:0] RST_SRC_HEIGHT = 12'd600;
   localparam logic [8:0]  RST_OUT_WIDTH  = 9'd175;
   localparam logic [10:0] RST_OUT_HEIGHT = 11'd300;

   // ceil(2^28 / 1000), exact for every weighted sum below 2^18
   localparam logic [18:0] RECIP_1000 = 19'd268436;
   localparam int          RECIP_SHIFT = 28;

   typedef struct packed {
      logic [7:0]       luma;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             emit;
      logic             last;
   } item_type;

   typedef struct packed {
      logic       pixel_white;
      logic [7:0] out_x;
      logic [9:0] out_y;
      logic       frame_last;
   } result_type;

   // c*255/31 for a 5-bit channel
   function automatic logic [7:0] expand5(input logic [4:0] c);
      logic [2:0] f;
      f = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
        + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
      return {c, 3'b000} + 8'(f);
   endfunction

   // c*255/63 for a 6-bit channel
   function automatic logic [7:0] expand6(input logic [5:0] c);
      logic [1:0] f;
      f = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
      return {c, 2'b00} + 8'(f);
   endfunction

   function automatic logic [17:0] weighted_luma(input logic [15:0] p);
      logic [7:0] r8;
      logic [7:0] g8;
      logic [7:0] b8;
      r8 = expand5(p[15:11]);
      g8 = expand6(p[10:5]);
      b8 = expand5(p[4:0]);
      return 18'(r8 * 18'd299) + 18'(g8 * 18'd587) + 18'(b8 * 18'd114);
   endfunction

   function automatic logic [3:0] bayer4(input logic [1:0] y, input logic [1:0] x);
      logic [3:0] v;
      case (y)
         2'd0: begin
            case (x)
               2'd0: v = 4'd0;
               2'd1: v = 4'd8;
               2'd2: v = 4'd2;
               default: v = 4'd10;
            endcase
         end
         2'd1: begin
            case (x)
               2'd0: v = 4'd12;
               2'd1: v = 4'd4;
               2'd2: v = 4'd14;
               default: v = 4'd6;
            endcase
         end
         2'd2: begin
            case (x)
               2'd0: v = 4'd3;
               2'd1: v = 4'd11;
               2'd2: v = 4'd1;
               default: v = 4'd9;
            endcase
         end
         default: begin
            case (x)
               2'd0: v = 4'd15;
               2'd1: v = 4'd7;
               2'd2: v = 4'd13;
               default: v = 4'd5;
            endcase
         end
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/bdd_fifo.sv -----
// small first-in first-out queue
module bdd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/bdd_front.sv -----
// front end: footprint tracking, luma and item classification
module bdd_front #(
   parameter int MAX_OUT_WIDTH  = 256,
   parameter int MAX_OUT_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [11:0]      src_width,
   input  logic [11:0]      src_height,
   input  logic [8:0]       out_width,
   input  logic [10:0]      out_height,
   input  logic             push,
   input  logic [15:0]      pixel_rgb565,
   output logic             full,
   output logic             q_push,
   output bdd_pkg::item_type q_item,
   input  logic             q_full
);
   import bdd_pkg::*;

   localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int RW = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
   localparam logic [12:0] MAX_W = 13'(MAX_OUT_WIDTH);
   localparam logic [12:0] MAX_H = 13'(MAX_OUT_HEIGHT);

   typedef enum logic [2:0] {
      ST_DIVC = 3'b001,
      ST_DIVR = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type   st_ff, st_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] quo_ff, quo_in;
   logic [11:0] q0c_ff, q0c_in, r0c_ff, r0c_in;
   logic [11:0] q0r_ff, q0r_in, r0r_ff, r0r_in;
   logic [11:0] scol_ff, scol_in, srow_ff, srow_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [RW-1:0] orow_ff, orow_in;
   logic [11:0] cb_ff, cb_in, cr_ff, cr_in;
   logic [11:0] rb_ff, rb_in, rr_ff, rr_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [17:0] s1_wsum_ff;
   item_type    s1_item_ff, s1_item_in;

   logic [11:0] esw, esh, eow, eoh;
   logic [12:0] w0, w1, w2, h0, h1, h2;
   logic [11:0] dividend, divisor;
   logic [12:0] shifted;
   logic        ge;
   logic [12:0] div_diff;
   logic        accept;
   logic        col_fp_end, row_fp_end;
   logic [12:0] cr_sum, rr_sum;
   logic        c_carry, r_carry;
   logic [36:0] luma_prod;

   assign esw = (src_width == '0) ? 12'd1 : src_width;
   assign esh = (src_height == '0) ? 12'd1 : src_height;

   always_comb begin
      w0 = (out_width == '0) ? 13'd1 : 13'(out_width);
      w1 = (w0 > MAX_W) ? MAX_W : w0;
      w2 = (w1 > {1'b0, esw}) ? {1'b0, esw} : w1;
      h0 = (out_height == '0) ? 13'd1 : 13'(out_height);
      h1 = (h0 > MAX_H) ? MAX_H : h0;
      h2 = (h1 > {1'b0, esh}) ? {1'b0, esh} : h1;
   end
   assign eow = w2[11:0];
   assign eoh = h2[11:0];

   // restoring divide, one quotient bit per cycle
   assign dividend = (st_ff == ST_DIVC) ? esw : esh;
   assign divisor  = (st_ff == ST_DIVC) ? eow : eoh;
   assign shifted  = {rem_ff, dividend[4'd11 - cnt_ff]};
   assign ge       = (shifted >= {1'b0, divisor});
   assign div_diff = shifted - {1'b0, divisor};

   assign full   = (st_ff != ST_RUN) || (s1_valid_ff && q_full);
   assign accept = push && !full;

   assign col_fp_end = (13'(scol_ff) + 13'd1) >= {1'b0, cb_ff};
   assign row_fp_end = (13'(srow_ff) + 13'd1) >= {1'b0, rb_ff};

   // next footprint end: add quotient, carry the remainder
   assign cr_sum  = {1'b0, cr_ff} + {1'b0, r0c_ff};
   assign c_carry = cr_sum >= {1'b0, eow};
   assign rr_sum  = {1'b0, rr_ff} + {1'b0, r0r_ff};
   assign r_carry = rr_sum >= {1'b0, eoh};

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      q0c_in  = q0c_ff;
      r0c_in  = r0c_ff;
      q0r_in  = q0r_ff;
      r0r_in  = r0r_ff;
      scol_in = scol_ff;
      srow_in = srow_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      cb_in   = cb_ff;
      cr_in   = cr_ff;
      rb_in   = rb_ff;
      rr_in   = rr_ff;
      s1_item_in      = s1_item_ff;
      s1_item_in.luma = '0;
      s1_valid_in     = q_full ? s1_valid_ff : 1'b0;

      case (st_ff)
         ST_DIVC, ST_DIVR: begin
            rem_in = ge ? div_diff[11:0] : shifted[11:0];
            quo_in = {quo_ff[10:0], ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd11) begin
               cnt_in = '0;
               rem_in = '0;
               quo_in = '0;
               if (st_ff == ST_DIVC) begin
                  q0c_in = {quo_ff[10:0], ge};
                  r0c_in = ge ? div_diff[11:0] : shifted[11:0];
                  st_in  = ST_DIVR;
               end else begin
                  q0r_in  = {quo_ff[10:0], ge};
                  r0r_in  = ge ? div_diff[11:0] : shifted[11:0];
                  cb_in   = q0c_ff;
                  cr_in   = r0c_ff;
                  rb_in   = {quo_ff[10:0], ge};
                  rr_in   = ge ? div_diff[11:0] : shifted[11:0];
                  scol_in = '0;
                  srow_in = '0;
                  ocol_in = '0;
                  orow_in = '0;
                  st_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (accept) begin
               s1_valid_in     = 1'b1;
               s1_item_in.col  = COL_W'(ocol_ff);
               s1_item_in.row  = ROW_W'(orow_ff);
               s1_item_in.emit = col_fp_end && row_fp_end;
               s1_item_in.last = ((13'(ocol_ff) + 13'd1) == {1'b0, eow})
                              && ((13'(orow_ff) + 13'd1) == {1'b0, eoh});
               if ((13'(scol_ff) + 13'd1) >= {1'b0, esw}) begin
                  scol_in = '0;
                  ocol_in = '0;
                  cb_in   = q0c_ff;
                  cr_in   = r0c_ff;
                  if ((13'(srow_ff) + 13'd1) >= {1'b0, esh}) begin
                     srow_in = '0;
                     orow_in = '0;
                     rb_in   = q0r_ff;
                     rr_in   = r0r_ff;
                  end else begin
                     srow_in = srow_ff + 12'd1;
                     if (row_fp_end) begin
                        orow_in = orow_ff + 1'b1;
                        rb_in   = rb_ff + q0r_ff + 12'(r_carry);
                        rr_in   = r_carry ? 12'(rr_sum - {1'b0, eoh}) : rr_sum[11:0];
                     end
                  end
               end else begin
                  scol_in = scol_ff + 12'd1;
                  if (col_fp_end) begin
                     ocol_in = ocol_ff + 1'b1;
                     cb_in   = cb_ff + q0c_ff + 12'(c_carry);
                     cr_in   = c_carry ? 12'(cr_sum - {1'b0, eow}) : cr_sum[11:0];
                  end
               end
            end
         end
         default: begin
            st_in = ST_DIVC;
         end
      endcase

      if (restart) begin
         st_in       = ST_DIVC;
         cnt_in      = '0;
         rem_in      = '0;
         quo_in      = '0;
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_DIVC;
         cnt_ff      <= '0;
         rem_ff      <= '0;
         quo_ff      <= '0;
         s1_valid_ff <= 1'b0;
         q0c_ff      <= '0;
         r0c_ff      <= '0;
         q0r_ff      <= '0;
         r0r_ff      <= '0;
         scol_ff     <= '0;
         srow_ff     <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         cb_ff       <= '0;
         cr_ff       <= '0;
         rb_ff       <= '0;
         rr_ff       <= '0;
      end else begin
         st_ff       <= st_in;
         cnt_ff      <= cnt_in;
         rem_ff      <= rem_in;
         quo_ff      <= quo_in;
         s1_valid_ff <= s1_valid_in;
         q0c_ff      <= q0c_in;
         r0c_ff      <= r0c_in;
         q0r_ff      <= q0r_in;
         r0r_ff      <= r0r_in;
         scol_ff     <= scol_in;
         srow_ff     <= srow_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         cb_ff       <= cb_in;
         cr_ff       <= cr_in;
         rb_ff       <= rb_in;
         rr_ff       <= rr_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (accept) begin
         s1_wsum_ff <= weighted_luma(pixel_rgb565);
      end
   end

   // luma = weighted sum / 1000 by reciprocal
   assign luma_prod = 37'(s1_wsum_ff) * 37'(RECIP_1000);

   always_comb begin
      q_item      = s1_item_ff;
      q_item.luma = 8'(luma_prod >> RECIP_SHIFT);
   end
   assign q_push = s1_valid_ff;

endmodule

// ----- rtl/bdd_back.sv -----
// back end: column accumulators, average threshold and result issue
module bdd_back #(
   parameter int MAX_OUT_WIDTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               q_empty,
   output logic               q_pop,
   input  bdd_pkg::item_type   q_item,
   input  logic               o_full,
   output logic               o_push,
   output bdd_pkg::result_type o_data
);
   import bdd_pkg::*;

   localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_UPD  = 3'b010,
      B_EMIT = 3'b100
   } state_type;

   state_type   st_ff, st_in;
   item_type    cur_ff, cur_in;
   logic [55:0] mem [MAX_OUT_WIDTH];
   logic [55:0] rd_ff;
   logic [MAX_OUT_WIDTH-1:0] valid_ff;
   logic [31:0] sum_ff;
   logic [23:0] cnt_ff;
   logic [CW-1:0] addr;
   logic [CW-1:0] q_addr;
   logic [31:0] old_sum, new_sum;
   logic [23:0] old_cnt, new_cnt;
   logic        mem_we;
   logic [8:0]  thr;
   logic [32:0] prod;

   assign addr    = cur_ff.col[CW-1:0];
   assign q_addr  = q_item.col[CW-1:0];
   assign old_sum = valid_ff[addr] ? rd_ff[55:24] : '0;
   assign old_cnt = valid_ff[addr] ? rd_ff[23:0] : '0;
   assign new_sum = old_sum + 32'(cur_ff.luma);
   assign new_cnt = old_cnt + 24'd1;
   assign thr     = {5'(bayer4(cur_ff.row[1:0], cur_ff.col[1:0])) + 5'd1, 4'b0000};
   assign prod    = 33'(cnt_ff) * 33'(thr);

   always_comb begin
      st_in  = st_ff;
      cur_in = cur_ff;
      q_pop  = 1'b0;
      o_push = 1'b0;
      mem_we = 1'b0;
      case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               st_in  = B_UPD;
            end
         end
         B_UPD: begin
            if (cur_ff.emit) begin
               st_in = B_EMIT;
            end else begin
               mem_we = 1'b1;
               st_in  = B_IDLE;
            end
         end
         B_EMIT: begin
            if (!o_full) begin
               o_push = 1'b1;
               st_in  = B_IDLE;
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cur_ff <= cur_in;
      if (st_ff == B_UPD) begin
         sum_ff <= new_sum;
         cnt_ff <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (st_ff == B_UPD) begin
         valid_ff[addr] <= !cur_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= {new_sum, new_cnt};
      end
      if (q_pop) begin
         rd_ff <= mem[q_addr];
      end
   end

   // floor(sum/cnt) >= thr is the same as sum >= thr*cnt
   always_comb begin
      o_data.pixel_white = ({1'b0, sum_ff} >= prod);
      o_data.out_x       = cur_ff.col[7:0];
      o_data.out_y       = cur_ff.row[9:0];
      o_data.frame_last  = cur_ff.last;
   end

endmodule

// ----- rtl/box_downscale_bayer_dither_top.sv -----
// top level of the box downscaler with 4x4 ordered dither to one bit per pixel
// Takes RGB565 pixels in raster order and gives one black or white pixel per
// output footprint, with its column, row and a frame-end flag. The front end
// takes one pixel per cycle while full is low. The back end reads the column
// accumulator memory through a register, then writes it back or, where a
// footprint closes, issues the result; it takes no new pixel from its queue
// before it is through with the last one. After reset and after every
// register write the front end computes the footprint steps and holds full
// high meanwhile.
module box_downscale_bayer_dither_top #(
   parameter int MAX_OUT_WIDTH  = 256,
   parameter int MAX_OUT_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_pixel_rgb565,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_pixel_white,
   output logic [7:0]  rsp_out_x,
   output logic [9:0]  rsp_out_y,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bdd_pkg::*;

   logic [11:0] src_width_ff;
   logic [11:0] src_height_ff;
   logic [8:0]  out_width_ff;
   logic [10:0] out_height_ff;
   logic        cfg_we;
   logic        q_push, q_full, q_pop, q_empty;
   item_type    q_wr_item, q_rd_item;
   logic        o_push, o_full;
   result_type  o_wr_data, o_rd_data;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         out_width_ff  <= RST_OUT_WIDTH;
         out_height_ff <= RST_OUT_HEIGHT;
      end else if (cfg_we) begin
         case (paddr[3:2])
            REG_SRC_WIDTH:  src_width_ff  <= pwdata[11:0];
            REG_SRC_HEIGHT: src_height_ff <= pwdata[11:0];
            REG_OUT_WIDTH:  out_width_ff  <= pwdata[8:0];
            REG_OUT_HEIGHT: out_height_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SRC_WIDTH:  prdata = 32'(src_width_ff);
         REG_SRC_HEIGHT: prdata = 32'(src_height_ff);
         REG_OUT_WIDTH:  prdata = 32'(out_width_ff);
         REG_OUT_HEIGHT: prdata = 32'(out_height_ff);
         default:        prdata = '0;
      endcase
   end

   bdd_front #(
      .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
      .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (cfg_we),
      .src_width    (src_width_ff),
      .src_height   (src_height_ff),
      .out_width    (out_width_ff),
      .out_height   (out_height_ff),
      .push         (push),
      .pixel_rgb565 (req_pixel_rgb565),
      .full         (full),
      .q_push       (q_push),
      .q_item       (q_wr_item),
      .q_full       (q_full)
   );

   bdd_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (4)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_item),
      .empty   (q_empty)
   );

   bdd_back #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_we),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_item  (q_rd_item),
      .o_full  (o_full),
      .o_push  (o_push),
      .o_data  (o_wr_data)
   );

   bdd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (o_push),
      .wr_data (o_wr_data),
      .full    (o_full),
      .rd_en   (pop),
      .rd_data (o_rd_data),
      .empty   (empty)
   );

   assign rsp_pixel_white = o_rd_data.pixel_white;
   assign rsp_out_x       = o_rd_data.out_x;
   assign rsp_out_y       = o_rd_data.out_y;
   assign rsp_frame_last  = o_rd_data.frame_last;

endmodule

// ----- rtl/bdd_checker.sv -----
// port-level checks of the downscaler top level and their binding
module bdd_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic       psel,
   input logic       penable,
   input logic       pwrite,
   input logic       rsp_pixel_white,
   input logic [7:0] rsp_out_x,
   input logic [9:0] rsp_out_y,
   input logic       rsp_frame_last
);

   // nothing to deliver right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   // front end recomputes footprints after reset
   assert property (@(posedge clock) reset |=> full)
      else $error("input taken while footprints are computed after reset");

   // a register write restarts the frame and blocks input
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) |=> full)
      else $error("input taken right after a register write");

   // a waiting result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pixel_white) && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_frame_last)))
      else $error("waiting result changed before transfer");

endmodule

bind box_downscale_bayer_dither_top bdd_checker u_bdd_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .psel            (psel),
   .penable         (penable),
   .pwrite          (pwrite),
   .rsp_pixel_white (rsp_pixel_white),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_frame_last  (rsp_frame_last)
);
